/* design/ssb_pkg.sv */
// Shared types and constants for the strided slice bounds block.
// Field widths, beat layouts, register codes and the mask lookup helper.
// No dependencies.
package ssb_pkg;

  // Field widths
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 16;
  localparam int VAL_W      = 32;
  localparam int STRIDE_W   = 17;
  localparam int END_W      = 17;
  localparam int SLOT_W     = 3;
  localparam int MASK_W     = 6;
  localparam int WIDE_W     = VAL_W + 1;

  // Output shape capacity
  localparam int MAX_DIMS   = 6;
  localparam int SLOT_CNT_W = $clog2(MAX_DIMS + 1);

  // Bit-serial divider: one quotient bit per cycle
  localparam int DIV_STEPS  = DIM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = MASK_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BEGIN_MASK  = 2'd0,
    REG_END_MASK    = 2'd1,
    REG_SHRINK_MASK = 2'd2,
    REG_KEEP_SHRUNK = 2'd3
  } cfg_reg_t;

  // Input beat layout
  localparam int IN_IDX_LSB    = 0;
  localparam int IN_DIM_LSB    = IN_IDX_LSB + IDX_W;
  localparam int IN_SG_BIT     = IN_DIM_LSB + DIM_W;
  localparam int IN_SV_LSB     = IN_SG_BIT + 1;
  localparam int IN_EG_BIT     = IN_SV_LSB + VAL_W;
  localparam int IN_EV_LSB     = IN_EG_BIT + 1;
  localparam int IN_TG_BIT     = IN_EV_LSB + VAL_W;
  localparam int IN_TV_LSB     = IN_TG_BIT + 1;
  localparam int IN_USED_W     = IN_TV_LSB + STRIDE_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output beat layout
  localparam int OUT_START_LSB = 0;
  localparam int OUT_END_LSB   = OUT_START_LSB + DIM_W;
  localparam int OUT_STR_LSB   = OUT_END_LSB + END_W;
  localparam int OUT_WR_BIT    = OUT_STR_LSB + STRIDE_W;
  localparam int OUT_SLOT_LSB  = OUT_WR_BIT + 1;
  localparam int OUT_EXT_LSB   = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_STOP_BIT  = OUT_EXT_LSB + DIM_W;
  localparam int OUT_USED_W    = OUT_STOP_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // Extremes forced by the begin and end masks
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // Mask bit for a dimension; indexes past the mask read as zero
  function automatic logic mask_bit(input logic [MASK_W-1:0] m,
                                    input logic [IDX_W-1:0]  i);
    logic [(1 << IDX_W)-1:0] ext;
    ext = {{((1 << IDX_W) - MASK_W){1'b0}}, m};
    return ext[i];
  endfunction

endpackage

/* design/strided_slice_bounds_top.sv */
// Strided slice bounds: per-dimension start/end/stride normalization and
// output shape extents through a bit-serial restoring divider.
// Depends on ssb_pkg.
//
//  channel | ports                         | beat
//  --------+-------------------------------+------------------------------------
//  in      | in_tvalid/in_tready/in_tdata  | one dimension, in_tlast = last dim
//  out     | out_tvalid/out_tready/out_tdata| normalized bounds and shape entry
//  cfg     | cfg_we/cfg_addr/cfg_wdata     | mask and keep registers, no wait
//
// An input beat that writes a nonempty shape entry passes the clamp, shrink,
// setup, the one-bit-per-cycle divider for ceil(range/stride) and delivery
// steps; any other beat skips the divider. The next beat is taken in the
// cycle after the result is registered at the earliest.
// in_tready is high only while idle; with the out side stalled the next result
// waits in the delivery step. rst_n is synchronous and clears slots and stop.
module strided_slice_bounds_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg
  input  logic                               cfg_we,
  input  logic [ssb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ssb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // dim_index, dim_len, start_given, start_value, end_given, end_value,
  // stride_given, stride_value, zero pad
  input  logic [ssb_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  // out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // start_abs, end_abs, stride_out, shape_write, shape_slot, shape_extent,
  // shape_stopped, zero pad
  output logic [ssb_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);
  import ssb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLAMP, ST_FINAL, ST_SETUP, ST_DIV, ST_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [MASK_W-1:0] begin_mask_r, end_mask_r, shrink_mask_r;
  logic              keep_shrunk_r;

  // Run state
  logic [SLOT_CNT_W-1:0] next_slot_r;
  logic                  stopped_r;

  // Item registers
  logic [WIDE_W-1:0]    s_wrap_r, e_wrap_r;
  logic [DIM_W-1:0]     dim_r;
  logic [STRIDE_W-1:0]  stride_r;
  logic                 sg_r, eg_r, shrink_r, stride_pos_r, last_r;
  logic [DIM_W-1:0]     start_r;
  logic [END_W-1:0]     stop_r;
  logic                 wr_r, stopped_out_r, div_on_r;
  logic [SLOT_W-1:0]    slot_r;

  // Divider
  logic [DIM_W-1:0]     dq_r;
  logic [DIM_W-1:0]     rem_r;
  logic [STRIDE_W-1:0]  divisor_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  // Output register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tlast_r;

  // Input beat fields
  logic [IDX_W-1:0]    in_idx;
  logic [DIM_W-1:0]    in_dim;
  logic [VAL_W-1:0]    in_sv, in_ev;
  logic [STRIDE_W-1:0] in_tv, stride_eff;
  logic                stride_pos_in, shrink_in, in_accept;
  logic [VAL_W-1:0]    s_sel, e_sel;
  logic [WIDE_W-1:0]   s_wrap, e_wrap, dim_wide;

  // Clamp and shrink
  logic [END_W-1:0]  dim_ext, dim_m1, hi_c, lo_c, stop_c, shr_v;
  logic [DIM_W-1:0]  start_c;
  logic              s_ge_dim, e_gt_hi, e_lt_lo, shr_gt;

  // Range and shape decision
  logic [END_W:0]       range_v, range_abs, stride_abs;
  logic                 range_neg, range_zero, stride_neg, stride_zero;
  logic                 empty, wr_c, stopped_after, do_div;
  logic [DIM_W-1:0]     dvd;

  // Divider step and result
  logic [STRIDE_W-1:0]  trial, trial_diff;
  logic                 trial_ge;
  logic [DIM_W-1:0]     ext_c;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Pick extremes and wrap negative start and end by the size
  always_comb begin
    in_idx        = in_tdata[IN_IDX_LSB +: IDX_W];
    in_dim        = in_tdata[IN_DIM_LSB +: DIM_W];
    in_sv         = in_tdata[IN_SV_LSB +: VAL_W];
    in_ev         = in_tdata[IN_EV_LSB +: VAL_W];
    in_tv         = in_tdata[IN_TV_LSB +: STRIDE_W];
    stride_eff    = in_tdata[IN_TG_BIT] ? in_tv : {{(STRIDE_W-1){1'b0}}, 1'b1};
    stride_pos_in = !stride_eff[STRIDE_W-1] && (stride_eff != '0);
    shrink_in     = mask_bit(shrink_mask_r, in_idx);
    s_sel = mask_bit(begin_mask_r, in_idx) ? (stride_pos_in ? VAL_MIN : VAL_MAX) : in_sv;
    e_sel = (mask_bit(end_mask_r, in_idx) && !shrink_in) ?
            (stride_pos_in ? VAL_MAX : VAL_MIN) : in_ev;
    dim_wide = {{(WIDE_W-DIM_W){1'b0}}, in_dim};
    s_wrap   = {s_sel[VAL_W-1], s_sel} + (s_sel[VAL_W-1] ? dim_wide : '0);
    e_wrap   = {e_sel[VAL_W-1], e_sel} + (e_sel[VAL_W-1] ? dim_wide : '0);
  end

  // Clamp start to the size and end to the stride's window
  always_comb begin
    dim_ext  = {1'b0, dim_r};
    dim_m1   = dim_ext - {{(END_W-1){1'b0}}, 1'b1};
    hi_c     = stride_pos_r ? dim_ext : dim_m1;
    lo_c     = stride_pos_r ? '0 : '1;
    s_ge_dim = (s_wrap_r >= {{(WIDE_W-DIM_W){1'b0}}, dim_r});
    if (!sg_r || s_wrap_r[WIDE_W-1]) begin
      start_c = '0;
    end else if (s_ge_dim) begin
      start_c = (dim_r == '0) ? '0 : dim_m1[DIM_W-1:0];
    end else begin
      start_c = s_wrap_r[DIM_W-1:0];
    end
    e_gt_hi = $signed(e_wrap_r) > $signed({{(WIDE_W-END_W){hi_c[END_W-1]}}, hi_c});
    e_lt_lo = $signed(e_wrap_r) < $signed({{(WIDE_W-END_W){lo_c[END_W-1]}}, lo_c});
    priority if (!eg_r) begin
      stop_c = dim_ext;
    end else if (e_gt_hi) begin
      stop_c = hi_c;
    end else if (e_lt_lo) begin
      stop_c = lo_c;
    end else begin
      stop_c = e_wrap_r[END_W-1:0];
    end
    // Shrink: end is start plus one, bounded by the upper limit
    shr_v  = {1'b0, start_r} + {{(END_W-1){1'b0}}, 1'b1};
    shr_gt = $signed(shr_v) > $signed(hi_c);
  end

  // Classify the range and set up the divide
  always_comb begin
    range_v     = {stop_r[END_W-1], stop_r} - {2'b00, start_r};
    range_neg   = range_v[END_W];
    range_zero  = (range_v == '0);
    stride_neg  = stride_r[STRIDE_W-1];
    stride_zero = (stride_r == '0);
    empty = range_zero || (range_neg && !stride_neg) ||
            (!range_neg && !range_zero && (stride_neg || stride_zero));
    range_abs   = range_neg ? (~range_v + 1'b1) : range_v;
    dvd         = range_abs[DIM_W-1:0] - {{(DIM_W-1){1'b0}}, 1'b1};
    stride_abs  = stride_neg ? (~{stride_r[STRIDE_W-1], stride_r} + 1'b1)
                             : {stride_r[STRIDE_W-1], stride_r};
    wr_c = (keep_shrunk_r || !shrink_r) && !stopped_r &&
           (next_slot_r < SLOT_CNT_W'(MAX_DIMS));
    stopped_after = stopped_r || (wr_c && empty);
    do_div        = wr_c && !empty;
  end

  // One restoring divide step; extent is quotient plus one
  always_comb begin
    trial      = {rem_r, dq_r[DIM_W-1]};
    trial_ge   = (trial >= divisor_r);
    trial_diff = trial - divisor_r;
    ext_c      = div_on_r ? (dq_r + {{(DIM_W-1){1'b0}}, 1'b1}) : '0;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_mask_r  <= '0;
      end_mask_r    <= '0;
      shrink_mask_r <= '0;
      keep_shrunk_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_BEGIN_MASK:  begin_mask_r  <= cfg_wdata;
        REG_END_MASK:    end_mask_r    <= cfg_wdata;
        REG_SHRINK_MASK: shrink_mask_r <= cfg_wdata;
        REG_KEEP_SHRUNK: keep_shrunk_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequence one beat: clamp, shrink, decide, divide, deliver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_slot_r  <= '0;
      stopped_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // Drop the result beat once taken; the delivery step handles its own
      if (out_tready && state_r != ST_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            s_wrap_r     <= s_wrap;
            e_wrap_r     <= e_wrap;
            dim_r        <= in_dim;
            stride_r     <= stride_eff;
            stride_pos_r <= stride_pos_in;
            sg_r         <= in_tdata[IN_SG_BIT];
            eg_r         <= in_tdata[IN_EG_BIT];
            shrink_r     <= shrink_in;
            last_r       <= in_tlast;
            state_r      <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          start_r <= start_c;
          stop_r  <= stop_c;
          state_r <= ST_FINAL;
        end
        ST_FINAL: begin
          if (eg_r && shrink_r) begin
            stop_r <= shr_gt ? hi_c : shr_v;
          end
          state_r <= ST_SETUP;
        end
        ST_SETUP: begin
          wr_r          <= wr_c;
          slot_r        <= wr_c ? SLOT_W'(next_slot_r) : '0;
          stopped_out_r <= stopped_after;
          div_on_r      <= do_div;
          dq_r          <= dvd;
          rem_r         <= '0;
          divisor_r     <= stride_abs[STRIDE_W-1:0];
          cnt_r         <= DIV_CNT_W'(DIV_STEPS - 1);
          stopped_r     <= last_r ? 1'b0 : stopped_after;
          if (last_r) begin
            next_slot_r <= '0;
          end else if (do_div) begin
            next_slot_r <= next_slot_r + SLOT_CNT_W'(1);
          end
          state_r <= do_div ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          rem_r <= trial_ge ? trial_diff[DIM_W-1:0] : trial[DIM_W-1:0];
          dq_r  <= {dq_r[DIM_W-2:0], trial_ge};
          cnt_r <= cnt_r - DIV_CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, stopped_out_r, ext_c,
                             slot_r, wr_r, stride_r, stop_r, start_r};
            out_tlast_r  <= last_r;
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A result appears only out of the delivery step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside delivery step");

  // The slot counter never passes the shape capacity
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= SLOT_CNT_W'(MAX_DIMS))
    else $error("slot counter past shape capacity");

  // Divider ends after its last step
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> (state_r == ST_DONE))
    else $error("divider overran its step count");

  // A beat without a shape entry carries zero slot and extent
  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[OUT_WR_BIT]) |->
      (out_tdata[OUT_SLOT_LSB +: SLOT_W] == '0 && out_tdata[OUT_EXT_LSB +: DIM_W] == '0))
    else $error("shape fields set without a shape entry");

endmodule

/* test/testbench.sv */
// Self-checking testbench for strided_slice_bounds_top: drives dimension beats,
// predicts normalized bounds and shape entries in-line, and checks every result.
// Depends on ssb_pkg and the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssb_pkg::*;

  localparam longint INT_LO    = -(longint'(1) << 31);
  localparam longint INT_HI    = (longint'(1) << 31) - 1;
  localparam int     SETTLE    = 30;
  localparam int     HOLD_LEN  = 400;
  localparam int     PHASES    = 11;
  localparam int     PER_PHASE = 100;

  typedef struct {
    logic [IDX_W-1:0]    idx;
    logic [DIM_W-1:0]    size;
    logic                start_given;
    logic [VAL_W-1:0]    start_val;
    logic                end_given;
    logic [VAL_W-1:0]    end_val;
    logic                stride_given;
    logic [STRIDE_W-1:0] stride_val;
    logic                last;
  } dim_item_t;

  typedef struct {
    logic [DIM_W-1:0]    start_abs;
    logic [END_W-1:0]    end_abs;
    logic [STRIDE_W-1:0] stride;
    logic                wr;
    logic [SLOT_W-1:0]   slot;
    logic [DIM_W-1:0]    extent;
    logic                stopped;
    logic                last;
  } slice_bounds_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tlast  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Register shadows and run state of the predictor
  logic [MASK_W-1:0] begin_mask_r  = '0;
  logic [MASK_W-1:0] end_mask_r    = '0;
  logic [MASK_W-1:0] shrink_mask_r = '0;
  logic              keep_shrunk_r = 1'b0;
  int                run_slot      = 0;
  logic              run_stopped   = 1'b0;

  dim_item_t     dim_q[$];
  dim_item_t     cur_dim;
  slice_bounds_t bounds_q[$];

  int beats_queued   = 0;
  int beats_accepted = 0;
  int beats_checked  = 0;
  int n_empty        = 0;
  int n_unwritten    = 0;
  int n_settings     = 1;
  int err_cnt        = 0;
  int send_idle_pct  = 14;
  int recv_idle_pct  = 53;
  bit stall_armed    = 1'b0;
  logic rx_hold      = 1'b0;

  strided_slice_bounds_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mask bit of a dimension; indexes past the mask width read as clear
  function automatic logic dim_bit(logic [MASK_W-1:0] m, logic [IDX_W-1:0] i);
    return (i < MASK_W) ? m[i] : 1'b0;
  endfunction

  // Expected bounds and shape entry for one accepted dimension beat
  function automatic slice_bounds_t predict_bounds(dim_item_t d);
    longint sz, stride, first, stop, span, mag, step, ext;
    logic shrink;
    slice_bounds_t r;
    sz     = longint'(d.size);
    stride = d.stride_given ? longint'($signed(d.stride_val)) : 1;
    shrink = dim_bit(shrink_mask_r, d.idx);
    first  = 0;
    ext    = 0;
    r.wr   = 1'b0;
    r.slot = '0;

    // Start: force extreme under the begin mask, wrap negatives, clamp
    if (d.start_given) begin
      first = longint'($signed(d.start_val));
      if (dim_bit(begin_mask_r, d.idx))
        first = (stride > 0) ? INT_LO : INT_HI;
      if (first < 0) first += sz;
      if (first > sz - 1) first = sz - 1;
      if (first < 0) first = 0;
    end

    // End: shrink takes one element, end mask forces extreme, then clamp
    if (!d.end_given) begin
      stop = sz;
    end else begin
      stop = longint'($signed(d.end_val));
      if (shrink) stop = first + 1;
      if (dim_bit(end_mask_r, d.idx) && !shrink)
        stop = (stride > 0) ? INT_HI : INT_LO;
      if (stop < 0) stop += sz;
      if (stride > 0) begin
        if (stop > sz) stop = sz;
        if (stop < 0) stop = 0;
      end else begin
        if (stop > sz - 1) stop = sz - 1;
        if (stop < -1) stop = -1;
      end
    end

    // Shape entry: empty or mismatched range writes zero and stops the run
    if ((keep_shrunk_r || !shrink) && !run_stopped && run_slot < MAX_DIMS) begin
      span   = stop - first;
      r.wr   = 1'b1;
      r.slot = SLOT_W'(run_slot);
      if (span == 0 || (span < 0 && stride >= 0) || (span > 0 && stride <= 0)) begin
        run_stopped = 1'b1;
        n_empty++;
      end else begin
        mag  = (span < 0) ? -span : span;
        step = (stride < 0) ? -stride : stride;
        ext  = (mag + step - 1) / step;
        run_slot++;
      end
    end else begin
      n_unwritten++;
    end

    r.start_abs = first[DIM_W-1:0];
    r.end_abs   = stop[END_W-1:0];
    r.stride    = stride[STRIDE_W-1:0];
    r.extent    = ext[DIM_W-1:0];
    r.stopped   = run_stopped;
    r.last      = d.last;
    if (d.last) begin
      run_slot    = 0;
      run_stopped = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_dim(dim_item_t d);
    logic [IN_TDATA_W-1:0] t;
    t = '0;
    t[IN_IDX_LSB +: IDX_W]   = d.idx;
    t[IN_DIM_LSB +: DIM_W]   = d.size;
    t[IN_SG_BIT]             = d.start_given;
    t[IN_SV_LSB +: VAL_W]    = d.start_val;
    t[IN_EG_BIT]             = d.end_given;
    t[IN_EV_LSB +: VAL_W]    = d.end_val;
    t[IN_TG_BIT]             = d.stride_given;
    t[IN_TV_LSB +: STRIDE_W] = d.stride_val;
    return t;
  endfunction

  function automatic slice_bounds_t unpack_bounds(logic [OUT_TDATA_W-1:0] t, logic l);
    slice_bounds_t r;
    r.start_abs = t[OUT_START_LSB +: DIM_W];
    r.end_abs   = t[OUT_END_LSB +: END_W];
    r.stride    = t[OUT_STR_LSB +: STRIDE_W];
    r.wr        = t[OUT_WR_BIT];
    r.slot      = t[OUT_SLOT_LSB +: SLOT_W];
    r.extent    = t[OUT_EXT_LSB +: DIM_W];
    r.stopped   = t[OUT_STOP_BIT];
    r.last      = l;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    $display("[%0t] beat %0d: %s got 0x%0h expected 0x%0h",
             $realtime, beats_checked, what, got, want);
  endtask

  // Driver: hold a beat until accepted, predict it on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        bounds_q.push_back(predict_bounds(cur_dim));
        beats_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (dim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_dim = dim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= pack_dim(cur_dim);
          in_tlast  <= cur_dim.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    slice_bounds_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = unpack_bounds(out_tdata, out_tlast);
        if (bounds_q.size() == 0) begin
          flag_mismatch("unexpected beat", 32'(got.start_abs), '0);
        end else begin
          want = bounds_q.pop_front();
          if (got.start_abs !== want.start_abs)
            flag_mismatch("start_abs", 32'(got.start_abs), 32'(want.start_abs));
          if (got.end_abs !== want.end_abs)
            flag_mismatch("end_abs", 32'(got.end_abs), 32'(want.end_abs));
          if (got.stride !== want.stride)
            flag_mismatch("stride_out", 32'(got.stride), 32'(want.stride));
          if (got.wr !== want.wr)
            flag_mismatch("shape_write", 32'(got.wr), 32'(want.wr));
          if (got.slot !== want.slot)
            flag_mismatch("shape_slot", 32'(got.slot), 32'(want.slot));
          if (got.extent !== want.extent)
            flag_mismatch("shape_extent", 32'(got.extent), 32'(want.extent));
          if (got.stopped !== want.stopped)
            flag_mismatch("shape_stopped", 32'(got.stopped), 32'(want.stopped));
          if (got.last !== want.last)
            flag_mismatch("last_out", 32'(got.last), 32'(want.last));
        end
        beats_checked++;
      end
      out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin : rx_stall
    wait (stall_armed);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic queue_dim(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] size,
                           logic sg, logic [VAL_W-1:0] sv,
                           logic eg, logic [VAL_W-1:0] ev,
                           logic tg, logic [STRIDE_W-1:0] tv, logic last);
    dim_item_t d;
    d = '{idx, size, sg, sv, eg, ev, tg, tv, last};
    dim_q.push_back(d);
    beats_queued++;
  endtask

  function automatic int unsigned pick_size();
    case ($urandom_range(19))
      0:       return 65535;
      1:       return 1;
      2:       return $urandom_range(1, 65535);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_bound(int unsigned sz);
    case ($urandom_range(11))
      0:       return $urandom;
      1:       return VAL_MIN;
      2:       return VAL_MAX;
      3:       return sz;
      4:       return -sz;
      default: return $urandom_range(4 * sz) - 2 * sz;
    endcase
  endfunction

  function automatic logic [STRIDE_W-1:0] pick_stride();
    int mag;
    case ($urandom_range(15))
      0:       return '0;
      1:       return STRIDE_W'($urandom);
      2:       return 17'h10000;
      3:       return 17'h0ffff;
      default: begin
        mag = $urandom_range(1, 4);
        return $urandom_range(1) ? STRIDE_W'(-mag) : STRIDE_W'(mag);
      end
    endcase
  endfunction

  // One tensor: dims in order with tlast on the final one; a few are noisy
  task automatic queue_run();
    int len;
    bit noisy;
    logic [IDX_W-1:0] idx;
    logic lst;
    int unsigned sz;
    len   = $urandom_range(1, 8);
    noisy = ($urandom_range(19) == 0);
    for (int k = 0; k < len; k++) begin
      idx = ($urandom_range(15) == 0) ? IDX_W'($urandom_range(7)) : IDX_W'(k);
      lst = (k == len - 1) || (noisy && $urandom_range(3) == 0);
      sz  = pick_size();
      queue_dim(idx, DIM_W'(sz), $urandom_range(4) != 0, pick_bound(sz),
                $urandom_range(4) != 0, pick_bound(sz),
                $urandom_range(4) != 0, pick_stride(), lst);
    end
  endtask

  task automatic write_reg(cfg_reg_t a, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    case (a)
      REG_BEGIN_MASK:  begin_mask_r  = v;
      REG_END_MASK:    end_mask_r    = v;
      REG_SHRINK_MASK: shrink_mask_r = v;
      REG_KEEP_SHRUNK: keep_shrunk_r = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [MASK_W-1:0] bm, logic [MASK_W-1:0] em,
                            logic [MASK_W-1:0] sm, logic [CFG_DATA_W-1:0] kw);
    write_reg(REG_BEGIN_MASK, bm);
    write_reg(REG_END_MASK, em);
    write_reg(REG_SHRINK_MASK, sm);
    write_reg(REG_KEEP_SHRUNK, kw);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Wait until every queued beat is in and every result is back, then settle
  task automatic wait_drained();
    while (beats_accepted != beats_queued || bounds_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values
    queue_dim(0, 1, 0, '0, 0, '0, 0, '0, 1);
    queue_dim(0, 16'hffff, 1, 32'hffff_ffff, 1, VAL_MAX, 1, 17'd1, 0);
    queue_dim(1, 16'hffff, 1, VAL_MIN, 1, VAL_MIN, 1, 17'h1ffff, 1);
    // zero stride stops the shape until tlast
    queue_dim(0, 10, 1, 32'd2, 1, 32'd8, 1, 17'd0, 0);
    queue_dim(1, 10, 0, '0, 0, '0, 0, '0, 0);
    queue_dim(7, 10, 1, 32'd1, 1, 32'd5, 1, 17'd1, 1);
    // stride extremes
    queue_dim(0, 16'hffff, 1, 32'hffff_ffff, 1, VAL_MIN, 1, 17'h10000, 0);
    queue_dim(1, 16'hffff, 1, '0, 1, VAL_MAX, 1, 17'h0ffff, 1);
    // end before start with a positive stride
    queue_dim(0, 20, 1, 32'd15, 1, 32'd5, 1, 17'd2, 1);
    // seven kept dims overflow the shape
    for (int k = 0; k < 7; k++)
      queue_dim(IDX_W'(k), 8, 0, '0, 0, '0, 0, '0, k == 6);
    wait_drained();

    // Directed, every mask set and shrunk dims kept
    set_config('1, '1, '1, '1);
    queue_dim(0, 12, 1, 32'd3, 1, 32'd9, 1, 17'd2, 0);
    queue_dim(2, 12, 1, 32'd3, 0, '0, 1, 17'd2, 0);
    queue_dim(6, 12, 1, 32'd3, 1, 32'd9, 1, 17'd2, 0);
    queue_dim(7, 12, 1, 32'd9, 1, 32'd3, 1, 17'h1ffff, 0);
    queue_dim(1, 12, 1, 32'd3, 1, 32'd9, 1, 17'h1fffd, 1);
    wait_drained();

    // Random tensors over several register settings and idle patterns
    for (int p = 1; p <= PHASES; p++) begin
      if (p == 5) begin
        send_idle_pct = 53;
        recv_idle_pct = 14;
      end else if (p == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_armed   = 1'b1;
      end
      if (p == 3)
        set_config('0, '0, '0, '0);
      else if (p == 7)
        set_config('1, '1, '1, 6'h01);
      else
        set_config(MASK_W'($urandom), MASK_W'($urandom), MASK_W'($urandom),
                   CFG_DATA_W'($urandom));
      while (dim_q.size() < PER_PHASE)
        queue_run();
      wait_drained();
    end

    if (bounds_q.size() != 0)
      flag_mismatch("results missing", 32'(bounds_q.size()), '0);
    $display("Checked %0d dimension beats under %0d register settings;", beats_checked,
             n_settings);
    $display("%0d empty ranges stopped a shape, %0d beats wrote no entry.", n_empty,
             n_unwritten);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
